>>> hdl/deq_pkg.sv
// deq_pkg: shared types, constants and helpers for the double-ended queue
// used by deq_ctrl, deq_dpath and double_ended_queue; depends on nothing

package deq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = IDX_W + 1;

   localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [2:0] ACT_POP_BACK   = 3'd3;
   localparam logic [2:0] ACT_LIST       = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] value;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic [1:0]         status;
      logic               last;
   } rsp_item_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_POP_OUT,
      FSM_LIST
   } fsm_state_type;

   typedef struct packed {
      logic       load;
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       pop_back;
      logic       walk_read;
      logic       emit;
      logic       emit_data;
      logic [1:0] emit_status;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       full;
      logic       empty;
      logic       walk_done;
   } stat_type;

   // ring index from a sum that stays below twice the depth
   function automatic logic [IDX_W-1:0] wrap_index(input logic [CNT_W-1:0] sum);
      logic [CNT_W-1:0] fixed;
      fixed = (sum >= CNT_W'(DEPTH)) ? (sum - CNT_W'(DEPTH)) : sum;
      return fixed[IDX_W-1:0];
   endfunction

endpackage

>>> hdl/deq_ctrl.sv
// deq_ctrl: sequencing state machine for the double-ended queue
// depends on deq_pkg; drives commands into deq_dpath from its status

module deq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  deq_pkg::stat_type stat,
   output deq_pkg::cmd_type  cmd,
   output logic              busy
);
   import deq_pkg::*;

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if ((stat.op inside {ACT_POP_FRONT, ACT_POP_BACK}) && !stat.empty) begin
               state_in = FSM_POP_OUT;
            end else if (stat.op == ACT_LIST && !stat.empty) begin
               state_in = FSM_LIST;
            end else begin
               state_in = FSM_IDLE;
            end
         end
         FSM_POP_OUT: begin
            state_in = FSM_IDLE;
         end
         FSM_LIST: begin
            if (stat.walk_done) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         FSM_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         FSM_EXEC: begin
            if (stat.op inside {ACT_PUSH_FRONT, ACT_PUSH_BACK}) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               if (stat.full) begin
                  cmd.emit_status = ST_FULL;
               end else begin
                  cmd.emit_status = ST_OK;
                  cmd.push_front  = (stat.op == ACT_PUSH_FRONT);
                  cmd.push_back   = (stat.op == ACT_PUSH_BACK);
               end
            end else if (stat.op inside {ACT_POP_FRONT, ACT_POP_BACK, ACT_LIST}) begin
               if (stat.empty) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_last   = 1'b1;
                  cmd.emit_status = ST_EMPTY;
               end else begin
                  cmd.pop_front = (stat.op == ACT_POP_FRONT);
                  cmd.pop_back  = (stat.op == ACT_POP_BACK);
                  cmd.walk_read = (stat.op == ACT_LIST);
               end
            end else begin
               cmd.emit        = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.emit_status = ST_OK;
            end
         end
         FSM_POP_OUT: begin
            cmd.emit        = 1'b1;
            cmd.emit_data   = 1'b1;
            cmd.emit_last   = 1'b1;
            cmd.emit_status = ST_OK;
         end
         FSM_LIST: begin
            cmd.emit        = 1'b1;
            cmd.emit_data   = 1'b1;
            cmd.emit_status = ST_OK;
            cmd.emit_last   = stat.walk_done;
            cmd.walk_read   = !stat.walk_done;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

>>> hdl/deq_dpath.sv
// deq_dpath: ring store, front index, occupancy, list walk and result register
// depends on deq_pkg; commanded by deq_ctrl

module deq_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  deq_pkg::req_item_type req_item,
   input  deq_pkg::cmd_type      cmd,
   output deq_pkg::stat_type     stat,
   output logic                  rsp_valid,
   output deq_pkg::rsp_item_type rsp_item
);
   import deq_pkg::*;

   logic signed [31:0] slots [DEPTH];

   logic [2:0]         op_ff;
   logic signed [31:0] value_ff;
   logic [IDX_W-1:0]   front_ff, front_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [CNT_W-1:0]   walk_ff;
   logic signed [31:0] rd_data_ff;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_item_ff;

   logic [CNT_W-1:0]   offset;
   logic [IDX_W-1:0]   ring_addr;
   logic [IDX_W-1:0]   front_dec;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;
   logic               mem_re;

   assign stat.op        = op_ff;
   assign stat.full      = (occ_ff == CNT_W'(DEPTH));
   assign stat.empty     = (occ_ff == '0);
   assign stat.walk_done = (walk_ff == occ_ff);

   always_comb begin
      if (cmd.push_back) begin
         offset = occ_ff;
      end else if (cmd.pop_back) begin
         offset = occ_ff - CNT_W'(1);
      end else if (cmd.pop_front) begin
         offset = CNT_W'(1);
      end else begin
         offset = walk_ff;
      end
   end

   assign ring_addr = wrap_index({1'b0, front_ff} + offset);
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : (front_ff - IDX_W'(1));
   assign mem_we    = cmd.push_front || cmd.push_back;
   assign mem_re    = cmd.pop_front || cmd.pop_back || cmd.walk_read;
   assign wr_addr   = cmd.push_front ? front_dec : ring_addr;
   assign rd_addr   = cmd.pop_front ? front_ff : ring_addr;

   always_comb begin
      front_in = front_ff;
      occ_in   = occ_ff;
      if (cmd.push_front) begin
         front_in = front_dec;
         occ_in   = occ_ff + CNT_W'(1);
      end else if (cmd.push_back) begin
         occ_in   = occ_ff + CNT_W'(1);
      end else if (cmd.pop_front) begin
         front_in = ring_addr;
         occ_in   = occ_ff - CNT_W'(1);
      end else if (cmd.pop_back) begin
         occ_in   = occ_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slots[wr_addr] <= value_ff;
      end
      if (mem_re) begin
         rd_data_ff <= slots[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         occ_ff       <= '0;
         walk_ff      <= '0;
         op_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= cmd.emit;
         if (cmd.load) begin
            op_ff   <= req_item.action;
            walk_ff <= '0;
         end else if (cmd.walk_read) begin
            walk_ff <= walk_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_item.value;
      end
      if (cmd.emit) begin
         rsp_item_ff.data   <= cmd.emit_data ? rd_data_ff : 32'sd0;
         rsp_item_ff.status <= cmd.emit_status;
         rsp_item_ff.last   <= cmd.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("occupancy beyond depth");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_front || cmd.push_back) |-> !stat.full)
      else $error("push into full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop_front || cmd.pop_back || cmd.walk_read) |-> !stat.empty)
      else $error("read from empty queue");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_read |-> (walk_ff < occ_ff))
      else $error("list walk past back element");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push_front || cmd.push_back || cmd.pop_front || cmd.pop_back)
      |=> $stable(occ_ff))
      else $error("occupancy changed without push or pop");
`endif

endmodule

>>> hdl/double_ended_queue.sv
// double_ended_queue: top level of the bounded double-ended queue
// depends on deq_pkg, deq_ctrl and deq_dpath

// An item is taken when start is high and busy is low, and its results come
// back on rsp_item, one per cycle in which rsp_valid is high; the receiver
// must take each result in that cycle. A push, an unknown action, a pop from
// an empty queue or a list of an empty queue is answered from the EXEC state;
// a pop with an element passes through EXEC and POP_OUT, and a list through
// EXEC and then LIST until its last element is out; the ring store's
// registered read port sets the extra state of pops and lists and the one
// result per cycle of a list. A result is registered in the result register
// before it shows on the ports, behind the ring store's read register when an
// element is read, and busy is low again in the cycle after the item's last
// result is registered, so that cycle already takes the next item. The queue
// holds DEPTH signed 32-bit values and starts empty after reset.

module double_ended_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  deq_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output deq_pkg::rsp_item_type rsp_item
);
   import deq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   deq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   deq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

>>> verif/tb_double_ended_queue.sv
// tb_double_ended_queue: self-checking testbench for the double-ended queue,
// predicting every result of pushes, pops and listings and comparing each one
// depends on deq_pkg and double_ended_queue
`timescale 1ns / 1ps

module tb_double_ended_queue;
   import deq_pkg::*;

   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam int         SETTLE_CYCLES = 24;

   class deque_tracker;
      logic signed [31:0] ring [DEPTH];
      int unsigned        head;
      int unsigned        fill;
      rsp_item_type       pending_results[$];

      function new();
         head = 0;
         fill = 0;
      endfunction

      function void add_result(logic signed [31:0] data, logic [1:0] status, logic last);
         rsp_item_type r;
         r.data   = data;
         r.status = status;
         r.last   = last;
         pending_results.push_back(r);
      endfunction

      function void note_request(req_item_type it);
         int unsigned slot;
         case (it.action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
               if (fill >= DEPTH) begin
                  add_result('0, ST_FULL, 1'b1);
               end else begin
                  if (it.action == ACT_PUSH_FRONT) begin
                     head = (head == 0) ? DEPTH - 1 : head - 1;
                     ring[head] = it.value;
                  end else begin
                     ring[(head + fill) % DEPTH] = it.value;
                  end
                  fill++;
                  add_result('0, ST_OK, 1'b1);
               end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
               if (fill == 0) begin
                  add_result('0, ST_EMPTY, 1'b1);
               end else begin
                  if (it.action == ACT_POP_FRONT) begin
                     slot = head;
                     head = (head + 1) % DEPTH;
                  end else begin
                     slot = (head + fill - 1) % DEPTH;
                  end
                  fill--;
                  add_result(ring[slot], ST_OK, 1'b1);
               end
            end
            ACT_LIST: begin
               if (fill == 0) begin
                  add_result('0, ST_EMPTY, 1'b1);
               end else begin
                  for (int k = 0; k < fill; k++)
                     add_result(ring[(head + k) % DEPTH], ST_OK, k + 1 == fill);
               end
            end
            default: begin
               add_result('0, ST_OK, 1'b1);
            end
         endcase
      endfunction

      function bit check_response(rsp_item_type got, output string why);
         rsp_item_type want;
         why = "";
         if (pending_results.size() == 0) begin
            why = $sformatf("unexpected result data %0d status %0d last %0d",
                            got.data, got.status, got.last);
            return 1'b0;
         end
         want = pending_results.pop_front();
         if (got.data !== want.data)
            why = {why, $sformatf(" data %0d/%0d", got.data, want.data)};
         if (got.status !== want.status)
            why = {why, $sformatf(" status %0d/%0d", got.status, want.status)};
         if (got.last !== want.last)
            why = {why, $sformatf(" last %0d/%0d", got.last, want.last)};
         if (why != "") begin
            why = {"result got/expected:", why};
            return 1'b0;
         end
         return 1'b1;
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   deque_tracker sb;
   int           fail_count;
   string        why;

   double_ended_queue u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (fail_count < 40)
         $display("mismatch at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (!sb.check_response(rsp_item, why))
               report_mismatch(why);
         end
         if (start && !busy)
            sb.note_request(req_item);
      end
   end

   function automatic req_item_type make_item(logic [2:0] action, logic signed [31:0] value);
      req_item_type it;
      it.action = action;
      it.value  = value;
      return it;
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_action(int push_pct);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5)
         return 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
      if (r < 15)
         return ACT_LIST;
      if ($urandom_range(99) < push_pct)
         return $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      return $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
   endfunction

   // hold the item until the edge that takes it
   task automatic send_item(input req_item_type it, input int idle_pct);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_item <= make_item(ACT_LIST, $urandom);
         @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      while (busy)
         @(negedge clock);
      @(posedge clock);
   endtask

   // segments lean toward filling, draining or neither so full and empty both occur
   task automatic run_random(input int count, input int idle_pct);
      int push_pct;
      int offset;
      offset = $urandom_range(2);
      for (int k = 0; k < count; k++) begin
         case ((k / 30 + offset) % 3)
            0: push_pct = 85;
            1: push_pct = 15;
            default: push_pct = 50;
         endcase
         send_item(make_item(pick_action(push_pct), pick_value()), idle_pct);
      end
   endtask

   initial begin
      sb         = new();
      fail_count = 0;
      reset      = 1'b1;
      start      = 1'b0;
      req_item   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(make_item(ACT_LIST, 32'sh7fff_ffff), 0);
      send_item(make_item(ACT_POP_FRONT, -32'sd1), 0);
      send_item(make_item(ACT_POP_BACK, 32'sh8000_0000), 0);
      send_item(make_item(3'd5, $urandom), 0);
      send_item(make_item(3'd6, $urandom), 0);
      send_item(make_item(ACT_SPARE_HI, $urandom), 0);
      send_item(make_item(ACT_PUSH_FRONT, 32'sh8000_0000), 0);
      send_item(make_item(ACT_PUSH_BACK, 32'sh7fff_ffff), 0);
      send_item(make_item(ACT_PUSH_FRONT, '0), 0);
      send_item(make_item(ACT_PUSH_BACK, -32'sd1), 0);
      send_item(make_item(ACT_LIST, '0), 0);
      send_item(make_item(ACT_POP_BACK, '0), 0);
      send_item(make_item(ACT_POP_FRONT, -32'sd1), 0);
      send_item(make_item(ACT_LIST, -32'sd1), 0);
      send_item(make_item(ACT_POP_FRONT, '0), 0);
      send_item(make_item(ACT_POP_BACK, '0), 0);
      send_item(make_item(ACT_LIST, '0), 0);

      run_random(87, 13);
      run_random(87, 60);
      run_random(87, 0);

      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
